// ===== rtl/swqt_pkg.sv =====
// shared types and constants for the semaphore wait queue table
package swqt_pkg;

  localparam int MAX_PROCS = 32;
  localparam int KEY_BITS  = 32;
  localparam int PIDX_W    = $clog2(MAX_PROCS);
  localparam int CMD_W     = 2;
  localparam int PID_W     = 5;
  localparam int IN_KEY_W  = 32;
  localparam int ST_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_OUT    = 2'd2,
    CMD_HEAD   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ACT,
    S_WALK,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic act;
    logic walk;
    logic fin;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic early_done;
    logic scan_end;
    logic go_walk;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/semaphore_wait_queue_table.sv =====
// semaphore wait queue table top level
//
// channel  dir  tdata fields (low bit first)
// s_axis   in   command[1:0] sem_key[33:2] proc_id[38:34] zero[39]
// m_axis   out  status[1:0] result_valid[2] result_proc[7:3]
//
// one word at a time; the time per word is set by the
// key scan over the descriptors and the walk along one queue's links.
// insert, remove and peek never walk a queue.
// reset clears the used and blocked flags at once; no clearing pass.
// a waiting output word holds the block in its final state until taken.
module semaphore_wait_queue_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command, sem_key, proc_id, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // status, result_valid, result_proc
);

  swqt_pkg::ctl_t ctl;
  swqt_pkg::sts_t sts;
  logic [swqt_pkg::ST_W-1:0]  st;
  logic                       rv;
  logic [swqt_pkg::PID_W-1:0] rp;

  swqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  swqt_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_command (s_axis_tdata[1:0]),
    .in_key     (s_axis_tdata[33:2]),
    .in_proc    (s_axis_tdata[38:34]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (st),
    .out_rvalid (rv),
    .out_rproc  (rp)
  );

  assign m_axis_tdata = {rp, rv, st};

endmodule

// ===== rtl/swqt_ctrl.sv =====
// command sequencer for the semaphore wait queue table
module swqt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swqt_pkg::sts_t sts,
  output swqt_pkg::ctl_t ctl
);

  swqt_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swqt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      swqt_pkg::S_IDLE:  if (in_valid) state_next = swqt_pkg::S_CHECK;
      swqt_pkg::S_CHECK: state_next = sts.early_done ? swqt_pkg::S_FIN : swqt_pkg::S_SCAN;
      swqt_pkg::S_SCAN:  if (sts.scan_end) state_next = swqt_pkg::S_ACT;
      swqt_pkg::S_ACT:   state_next = sts.go_walk ? swqt_pkg::S_WALK : swqt_pkg::S_FIN;
      swqt_pkg::S_WALK:  if (sts.walk_end) state_next = swqt_pkg::S_FIN;
      swqt_pkg::S_FIN:   if (sts.out_free) state_next = swqt_pkg::S_IDLE;
      default:           state_next = swqt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready  = (state == swqt_pkg::S_IDLE);
    ctl.load  = (state == swqt_pkg::S_IDLE) && in_valid;
    ctl.check = (state == swqt_pkg::S_CHECK);
    ctl.scan  = (state == swqt_pkg::S_SCAN);
    ctl.act   = (state == swqt_pkg::S_ACT);
    ctl.walk  = (state == swqt_pkg::S_WALK);
    ctl.fin   = (state == swqt_pkg::S_FIN) && sts.out_free;
  end

endmodule

// ===== rtl/swqt_dpath.sv =====
// descriptor and process tables with the search and unlink datapath
module swqt_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  swqt_pkg::ctl_t                ctl,
  output swqt_pkg::sts_t                sts,
  input  logic [swqt_pkg::CMD_W-1:0]    in_command,
  input  logic [swqt_pkg::IN_KEY_W-1:0] in_key,
  input  logic [swqt_pkg::PID_W-1:0]    in_proc,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swqt_pkg::ST_W-1:0]     out_status,
  output logic                          out_rvalid,
  output logic [swqt_pkg::PID_W-1:0]    out_rproc
);

  localparam int N = swqt_pkg::MAX_PROCS;
  localparam int W = swqt_pkg::PIDX_W;
  localparam int K = swqt_pkg::KEY_BITS;

  // tables
  logic [N-1:0] desc_used;
  logic [N-1:0] proc_blocked;
  logic [K-1:0] desc_key      [N];
  logic [W-1:0] desc_head     [N];
  logic [W-1:0] desc_tail     [N];
  logic [W-1:0] proc_next     [N];
  logic [K-1:0] proc_wait_key [N];

  // command registers
  swqt_pkg::cmd_t          c_cmd;
  logic [K-1:0]            c_key;
  logic [swqt_pkg::PID_W-1:0] c_p;
  logic                    p_ok;
  logic [W-1:0]            pi;
  logic [W-1:0]            d_idx;
  logic                    hit;
  logic [W-1:0]            hit_d;
  logic                    free_ok;
  logic [W-1:0]            free_d;
  logic [W-1:0]            prev;
  logic [W-1:0]            p_next;
  logic [W-1:0]            steps;
  swqt_pkg::status_t       r_status;
  logic                    r_valid;
  logic [W-1:0]            r_proc;

  logic                    match;
  logic [W-1:0]            h_hit;
  logic [W-1:0]            t_hit;
  logic [W-1:0]            nx;

  assign pi    = c_p[W-1:0];
  assign p_ok  = (32'(c_p) < 32'(N));
  assign match = desc_used[d_idx] && (desc_key[d_idx] == c_key);
  assign h_hit = desc_head[hit_d];
  assign t_hit = desc_tail[hit_d];
  assign nx    = proc_next[prev];

  // status toward the controller
  always_comb begin
    sts.early_done = 1'b0;
    case (c_cmd)
      swqt_pkg::CMD_INSERT: sts.early_done = !p_ok || proc_blocked[pi];
      swqt_pkg::CMD_OUT:    sts.early_done = !p_ok || !proc_blocked[pi];
      default:              sts.early_done = 1'b0;
    endcase
    sts.scan_end = match || (d_idx == W'(N - 1));
    sts.go_walk  = (c_cmd == swqt_pkg::CMD_OUT) && hit && (h_hit != pi);
    sts.walk_end = (prev == t_hit) || (nx == pi) || (steps == W'(N - 1));
    sts.out_free = !out_valid || out_ready;
  end

  // flag tables, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_used    <= '0;
      proc_blocked <= '0;
    end else if (ctl.act) begin
      case (c_cmd)
        swqt_pkg::CMD_INSERT: begin
          if (hit) begin
            proc_blocked[pi] <= 1'b1;
          end else if (free_ok) begin
            desc_used[free_d] <= 1'b1;
            proc_blocked[pi]  <= 1'b1;
          end
        end
        swqt_pkg::CMD_REMOVE, swqt_pkg::CMD_OUT: begin
          if (hit && (c_cmd == swqt_pkg::CMD_REMOVE || h_hit == pi)) begin
            if (h_hit == t_hit) desc_used[hit_d] <= 1'b0;
            proc_blocked[h_hit] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (ctl.walk) begin
      if (prev != t_hit && nx == pi) proc_blocked[pi] <= 1'b0;
    end
  end

  // payload tables
  always_ff @(posedge clk) begin
    if (ctl.check && c_cmd == swqt_pkg::CMD_OUT) begin
      c_key <= proc_wait_key[pi];
    end else if (ctl.load) begin
      c_key <= in_key[K-1:0];
    end
    if (ctl.act) begin
      case (c_cmd)
        swqt_pkg::CMD_INSERT: begin
          if (hit) begin
            proc_next[t_hit]  <= pi;
            desc_tail[hit_d]  <= pi;
            proc_wait_key[pi] <= c_key;
          end else if (free_ok) begin
            desc_key[free_d]  <= c_key;
            desc_head[free_d] <= pi;
            desc_tail[free_d] <= pi;
            proc_wait_key[pi] <= c_key;
          end
        end
        swqt_pkg::CMD_REMOVE, swqt_pkg::CMD_OUT: begin
          if (hit && (c_cmd == swqt_pkg::CMD_REMOVE || h_hit == pi) && h_hit != t_hit)
            desc_head[hit_d] <= proc_next[h_hit];
        end
        default: ;
      endcase
    end else if (ctl.walk) begin
      if (prev != t_hit && nx == pi) begin
        proc_next[prev] <= p_next;
        if (t_hit == pi) desc_tail[hit_d] <= prev;
      end
    end
  end

  // command registers, scan and walk
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_cmd <= swqt_pkg::cmd_t'(in_command);
      c_p   <= in_proc;
    end
    if (ctl.check) begin
      d_idx    <= '0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
      r_status <= swqt_pkg::ST_NOTFOUND;
      r_valid  <= 1'b0;
      r_proc   <= '0;
      if (c_cmd == swqt_pkg::CMD_INSERT && p_ok && proc_blocked[pi])
        r_status <= swqt_pkg::ST_BLOCKED;
    end
    if (ctl.scan) begin
      d_idx <= d_idx + W'(1);
      if (match) begin
        hit   <= 1'b1;
        hit_d <= d_idx;
      end else if (!desc_used[d_idx] && !free_ok) begin
        free_ok <= 1'b1;
        free_d  <= d_idx;
      end
    end
    if (ctl.act) begin
      prev   <= h_hit;
      p_next <= proc_next[pi];
      steps  <= '0;
      case (c_cmd)
        swqt_pkg::CMD_INSERT:
          r_status <= (hit || free_ok) ? swqt_pkg::ST_OK : swqt_pkg::ST_NOFREE;
        swqt_pkg::CMD_REMOVE, swqt_pkg::CMD_HEAD: begin
          if (hit) begin
            r_status <= swqt_pkg::ST_OK;
            r_valid  <= 1'b1;
            r_proc   <= h_hit;
          end
        end
        default: begin
          if (hit && h_hit == pi) begin
            r_status <= swqt_pkg::ST_OK;
            r_valid  <= 1'b1;
            r_proc   <= pi;
          end
        end
      endcase
    end
    if (ctl.walk) begin
      prev  <= nx;
      steps <= steps + W'(1);
      if (prev != t_hit && nx == pi) begin
        r_status <= swqt_pkg::ST_OK;
        r_valid  <= 1'b1;
        r_proc   <= pi;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_status <= r_status;
      out_rvalid <= r_valid;
      out_rproc  <= swqt_pkg::PID_W'(r_proc);
    end
  end

endmodule

// ===== bench/tb.sv =====
// testbench for the semaphore wait queue table: directed table, a fill of every descriptor, then random traffic
`timescale 1ns / 100ps

module tb;
  import swqt_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int DRAIN = 4 * MAX_PROCS + 16;

  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [IN_KEY_W-1:0] key;
    cmd_t                cmd;
  } cmd_word_t;

  typedef struct packed {
    logic [PID_W-1:0] proc_id;
    logic             hit;
    status_t          status;
  } reply_t;

  typedef struct {
    cmd_t                cmd;
    logic [IN_KEY_W-1:0] key;
    logic [PID_W-1:0]    pid;
    logic                known;
    status_t             status;
    logic                hit;
    logic [PID_W-1:0]    proc_id;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  semaphore_wait_queue_table u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),   // command, sem_key, proc_id, zero pad
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)    // status, result_valid, result_proc
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the table
  logic                used_q  [MAX_PROCS];
  logic [KEY_BITS-1:0] dkey_q  [MAX_PROCS];
  int                  head_q  [MAX_PROCS];
  int                  tail_q  [MAX_PROCS];
  int                  next_q  [MAX_PROCS];
  logic                blk_q   [MAX_PROCS];
  logic [KEY_BITS-1:0] wkey_q  [MAX_PROCS];

  reply_t pending_replies[$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle = 20;
  int     recv_idle = 67;

  task automatic report(string what, reply_t got, reply_t want);
    errors++;
    $display("mismatch %s: got st=%0d v=%0d p=%0d want st=%0d v=%0d p=%0d", what,
             got.status, got.hit, got.proc_id, want.status, want.hit, want.proc_id);
  endtask

  function automatic int find_desc(logic [KEY_BITS-1:0] k);
    for (int d = 0; d < MAX_PROCS; d++)
      if (used_q[d] && dkey_q[d] == k) return d;
    return -1;
  endfunction

  function automatic int pop_oldest(int d);
    int h;
    h = head_q[d];
    if (h == tail_q[d]) used_q[d] = 1'b0;
    else head_q[d] = next_q[h];
    blk_q[h] = 1'b0;
    return h;
  endfunction

  // next-state and reply of the table for one command word
  function automatic reply_t table_step(cmd_t c, logic [IN_KEY_W-1:0] kin, int p);
    reply_t r;
    logic [KEY_BITS-1:0] k;
    int d, prv, nx;
    r = '{proc_id: '0, hit: 1'b0, status: ST_NOTFOUND};
    k = kin[KEY_BITS-1:0];
    case (c)
      CMD_INSERT: begin
        if (blk_q[p]) r.status = ST_BLOCKED;
        else begin
          d = find_desc(k);
          if (d < 0) begin
            for (int f = 0; f < MAX_PROCS; f++)
              if (!used_q[f]) begin d = f; break; end
            if (d >= 0) begin
              used_q[d] = 1'b1; dkey_q[d] = k; head_q[d] = p; tail_q[d] = p;
            end
          end else begin
            next_q[tail_q[d]] = p; tail_q[d] = p;
          end
          if (d < 0) r.status = ST_NOFREE;
          else begin
            blk_q[p] = 1'b1; wkey_q[p] = k; r.status = ST_OK;
          end
        end
      end
      CMD_REMOVE, CMD_HEAD: begin
        d = find_desc(k);
        if (d >= 0) begin
          r.status = ST_OK; r.hit = 1'b1;
          r.proc_id = PID_W'((c == CMD_REMOVE) ? pop_oldest(d) : head_q[d]);
        end
      end
      default: begin
        if (blk_q[p]) begin
          d = find_desc(wkey_q[p]);
          if (d >= 0) begin
            if (head_q[d] == p) begin
              void'(pop_oldest(d)); r.status = ST_OK;
            end else begin
              prv = head_q[d];
              for (int s = 0; s < MAX_PROCS; s++) begin
                if (prv == tail_q[d]) break;
                nx = next_q[prv];
                if (nx == p) begin
                  next_q[prv] = next_q[p];
                  if (tail_q[d] == p) tail_q[d] = prv;
                  blk_q[p] = 1'b0; r.status = ST_OK;
                  break;
                end
                prv = nx;
              end
            end
            if (r.status == ST_OK) begin r.hit = 1'b1; r.proc_id = PID_W'(p); end
          end
        end
      end
    endcase
    return r;
  endfunction

  // send one word; the predicted reply is checked against the typed-in reply when known and queued at acceptance
  // valid stays up after acceptance until the next send or a drain drops it
  task automatic send_word(cmd_t c, logic [IN_KEY_W-1:0] k, logic [PID_W-1:0] p,
                           logic known, reply_t want);
    reply_t r;
    cmd_word_t w;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    w = '{pid: p, key: k, cmd: c};
    s_axis_tdata  <= {1'b0, w};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = table_step(c, k, p);
    if (known && r !== want) report("table row vs predictor", r, want);
    pending_replies.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // receiver side and reply check
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_replies.size() == 0) begin
          report("unexpected reply word", got, '0);
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) report("reply", got, want);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // directed rows
  row_t rows[$];
  function automatic row_t mk(cmd_t c, logic [31:0] k, int p, int kn,
                              status_t s, int h, int rp);
    row_t t;
    t = '{cmd: c, key: k, pid: PID_W'(p), known: 1'(kn), status: s, hit: 1'(h),
          proc_id: PID_W'(rp)};
    return t;
  endfunction

  // random command biased toward a small set of keys and toward inserts, for any process
  task automatic random_word();
    int sel;
    logic [31:0] k;
    cmd_t c;
    sel = $urandom_range(99);
    if (sel < 85)
      k = {26'b0, 3'($urandom_range(7)), 3'b0} ^ ((sel < 5) ? 32'hffff_fff0 : 32'h0);
    else k = $urandom;
    c = cmd_t'($urandom_range(99) < 45 ? CMD_INSERT : $urandom_range(3));
    send_word(c, k, PID_W'($urandom_range(MAX_PROCS - 1)), 1'b0, '0);
  endtask

  initial begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      used_q[i] = 1'b0; blk_q[i] = 1'b0; dkey_q[i] = '0; wkey_q[i] = '0;
      head_q[i] = 0; tail_q[i] = 0; next_q[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(mk(CMD_REMOVE, 32'h0, 0, 1, ST_NOTFOUND, 0, 0));
    rows.push_back(mk(CMD_HEAD, 32'hffffffff, 0, 1, ST_NOTFOUND, 0, 0));
    rows.push_back(mk(CMD_OUT, 32'h0, 31, 1, ST_NOTFOUND, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'hffffffff, 31, 1, ST_OK, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'hffffffff, 31, 1, ST_BLOCKED, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'hffffffff, 0, 1, ST_OK, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'hffffffff, 5, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_HEAD, 32'hffffffff, 0, 1, ST_OK, 1, 31));
    rows.push_back(mk(CMD_OUT, 32'h12345678, 0, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_OUT, 32'h0, 5, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_REMOVE, 32'hffffffff, 0, 1, ST_OK, 1, 31));
    rows.push_back(mk(CMD_REMOVE, 32'hffffffff, 0, 1, ST_NOTFOUND, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'h0, 7, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'h0, 8, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_INSERT, 32'h0, 9, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_OUT, 32'h0, 8, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_OUT, 32'h0, 9, 0, ST_OK, 0, 0));
    rows.push_back(mk(CMD_REMOVE, 32'h0, 0, 1, ST_OK, 1, 7));
    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].key, rows[i].pid, rows[i].known,
                '{proc_id: rows[i].proc_id, hit: rows[i].hit, status: rows[i].status});

    // fill every descriptor with its own key; every process then waits
    for (int i = 0; i < MAX_PROCS; i++)
      send_word(CMD_INSERT, 32'(32'h1000 + i), PID_W'(i), 1'b0, '0);
    wait_drained();
    send_word(CMD_INSERT, 32'hdead0000, PID_W'(3), 1'b1,
              '{proc_id: '0, hit: 1'b0, status: ST_BLOCKED});
    for (int i = 0; i < MAX_PROCS; i++)
      send_word(CMD_OUT, '0, PID_W'(i), 1'b0, '0);
    for (int i = 0; i < MAX_PROCS - 1; i++)
      send_word(CMD_INSERT, 32'(32'h2000 + i), PID_W'(i), 1'b0, '0);
    send_word(CMD_INSERT, 32'h2000, PID_W'(31), 1'b0, '0);

    // random traffic in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 20 : (ph == 1) ? 67 : 0;
      recv_idle = (ph == 0) ? 67 : (ph == 1) ? 20 : 0;
      for (int n = 0; n < 180; n++) begin
        random_word();
        if (n == 90) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
